[design/bpfa_pkg.sv]
// Shared types and constants of the first-fit buffer pool allocator.
// Holds the request and response structs and the status codes.
// No dependencies.
package bpfa_pkg;

    localparam int MAX_SLOTS_DEF = 20;

    localparam int TYPE_W   = 3;
    localparam int USER_W   = 8;
    localparam int IDX_W    = 5;
    localparam int ADDR_W   = 32;
    localparam int SIZE_W   = 32;
    localparam int STATUS_W = 2;
    localparam int ENTRY_W  = 5;

    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 72;

    typedef enum logic [TYPE_W-1:0] {
        REQ_LOAD    = 3'd0,
        REQ_ATTACH  = 3'd1,
        REQ_DETACH  = 3'd2,
        REQ_ALLOC   = 3'd3,
        REQ_RELEASE = 3'd4,
        REQ_QUERY   = 3'd5
    } req_kind_t;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [USER_W-1:0] user_id;
        logic [IDX_W-1:0]  entry_index;
        logic [ADDR_W-1:0] address_value;
        logic [SIZE_W-1:0] size_value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [ADDR_W-1:0]   granted_address;
        logic [SIZE_W-1:0]   granted_size;
        logic [IDX_W-1:0]    granted_index;
        logic                pool_cleared;
    } rsp_t;

endpackage

[design/bpfa_req_reg.sv]
// Input register of the buffer pool allocator: takes one request and unpacks it.
// Depends on bpfa_pkg.
module bpfa_req_reg
    import bpfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [TYPE_W-1:0]   s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                take,
    output logic                req_valid,
    output req_t                req
);

    logic valid_reg;
    logic valid_next;
    req_t req_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_reg.req_type      <= s_tuser;
            req_reg.user_id       <= s_tdata[7:0];
            req_reg.entry_index   <= s_tdata[12:8];
            req_reg.address_value <= s_tdata[44:13];
            req_reg.size_value    <= s_tdata[76:45];
        end
    end

    assign req_valid = valid_reg;
    assign req       = req_reg;

endmodule

[design/bpfa_pool.sv]
// Descriptor table, user count and entry count register of the allocator.
// Decides each request combinationally with parallel compares. Depends on bpfa_pkg.
module bpfa_pool
    import bpfa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    input  logic [ENTRY_W-1:0] cfg_data,
    input  logic               req_valid,
    input  req_t               req,
    output rsp_t               rsp
);

    localparam int SLOT_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int PAGE_SHIFT = 12;
    localparam logic [SIZE_W:0]   PAGE_MASK = (SIZE_W+1)'((1 << PAGE_SHIFT) - 1);
    localparam logic [SIZE_W-1:0] SIZE_CAP  = ~PAGE_MASK[SIZE_W-1:0];

    logic [ADDR_W-1:0]  addr_reg  [MAX_SLOTS];
    logic [ADDR_W-1:0]  addr_next [MAX_SLOTS];
    logic [SIZE_W-1:0]  size_reg  [MAX_SLOTS];
    logic [SIZE_W-1:0]  size_next [MAX_SLOTS];
    logic [USER_W-1:0]  owner_reg [MAX_SLOTS];
    logic [USER_W-1:0]  owner_next[MAX_SLOTS];
    logic [MAX_SLOTS-1:0] busy_reg;
    logic [MAX_SLOTS-1:0] busy_next;
    logic [USER_W-1:0]  user_count_reg;
    logic [USER_W-1:0]  user_count_next;
    logic               present_reg;
    logic               present_next;
    logic [ENTRY_W-1:0] entry_count_reg;
    logic [ENTRY_W-1:0] entry_count_next;

    logic [MAX_SLOTS-1:0] in_range;
    logic [MAX_SLOTS-1:0] fit_vec;
    logic [MAX_SLOTS-1:0] match_vec;
    logic [SLOT_W-1:0]    alloc_pick;
    logic [SLOT_W-1:0]    match_pick;
    logic [SIZE_W-1:0]    load_size;
    logic [USER_W-1:0]    count_dec;

    function automatic logic [SIZE_W-1:0] page_round(input logic [SIZE_W-1:0] s);
        logic [SIZE_W:0] sum;
        sum = ({1'b0, s} + PAGE_MASK) & ~PAGE_MASK;
        return sum[SIZE_W] ? SIZE_CAP : sum[SIZE_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] first_set(input logic [MAX_SLOTS-1:0] v);
        logic [SLOT_W-1:0] pos;
        pos = '0;
        for (int i = MAX_SLOTS - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = SLOT_W'(i);
            end
        end
        return pos;
    endfunction

    always_comb
    begin
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            in_range[i]  = i < int'(entry_count_reg);
            fit_vec[i]   = in_range[i] && !busy_reg[i] && (size_reg[i] >= req.size_value);
            match_vec[i] = in_range[i] && (addr_reg[i] == req.address_value);
        end
    end

    assign alloc_pick = first_set(fit_vec);
    assign match_pick = first_set(match_vec);
    assign load_size  = page_round(req.size_value);
    assign count_dec  = (user_count_reg != '0) ? user_count_reg - 1'b1 : '0;

    always_comb
    begin
        addr_next       = addr_reg;
        size_next       = size_reg;
        owner_next      = owner_reg;
        busy_next       = busy_reg;
        user_count_next = user_count_reg;
        present_next    = present_reg;
        rsp             = '0;
        rsp.status      = ST_REJECT;

        if (cfg_valid)
        begin
            entry_count_next = (int'(cfg_data) > MAX_SLOTS) ? ENTRY_W'(MAX_SLOTS) : cfg_data;
        end
        else
        begin
            entry_count_next = entry_count_reg;
        end

        if (req_valid)
        begin
            case (req_kind_t'(req.req_type))
                REQ_LOAD:
                begin
                    if (int'(req.entry_index) < MAX_SLOTS)
                    begin
                        for (int i = 0; i < MAX_SLOTS; i++)
                        begin
                            if (i == int'(req.entry_index))
                            begin
                                addr_next[i]  = req.address_value;
                                size_next[i]  = load_size;
                                owner_next[i] = '0;
                                busy_next[i]  = 1'b0;
                            end
                        end
                        present_next = 1'b1;
                        rsp.status   = ST_OK;
                    end
                end
                REQ_ATTACH:
                begin
                    if (present_reg)
                    begin
                        if (user_count_reg != '1)
                        begin
                            user_count_next = user_count_reg + 1'b1;
                        end
                        rsp.status = ST_OK;
                    end
                end
                REQ_DETACH:
                begin
                    if (present_reg)
                    begin
                        if (count_dec != '0)
                        begin
                            user_count_next = count_dec;
                            for (int i = 0; i < MAX_SLOTS; i++)
                            begin
                                if (in_range[i] && size_reg[i] != '0 && busy_reg[i]
                                    && owner_reg[i] == req.user_id)
                                begin
                                    busy_next[i] = 1'b0;
                                end
                            end
                        end
                        else
                        begin
                            for (int i = 0; i < MAX_SLOTS; i++)
                            begin
                                addr_next[i]  = '0;
                                size_next[i]  = '0;
                                owner_next[i] = '0;
                            end
                            busy_next        = '0;
                            user_count_next  = '0;
                            present_next     = 1'b0;
                            rsp.pool_cleared = 1'b1;
                        end
                        rsp.status = ST_OK;
                    end
                end
                REQ_ALLOC:
                begin
                    if (present_reg && fit_vec != '0)
                    begin
                        busy_next[alloc_pick]  = 1'b1;
                        owner_next[alloc_pick] = req.user_id;
                        rsp.granted_address    = addr_reg[alloc_pick];
                        rsp.granted_size       = size_reg[alloc_pick];
                        rsp.granted_index      = IDX_W'(alloc_pick);
                        rsp.status             = ST_OK;
                    end
                end
                REQ_RELEASE:
                begin
                    if (present_reg)
                    begin
                        if (match_vec != '0)
                        begin
                            busy_next[match_pick] = 1'b0;
                            rsp.granted_index     = IDX_W'(match_pick);
                            rsp.status            = ST_OK;
                        end
                        else
                        begin
                            rsp.status = ST_NOT_FOUND;
                        end
                    end
                end
                REQ_QUERY:
                begin
                    if (present_reg)
                    begin
                        rsp.found  = match_vec != '0;
                        rsp.status = ST_OK;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SLOTS; i++)
            begin
                addr_reg[i]  <= '0;
                size_reg[i]  <= '0;
                owner_reg[i] <= '0;
            end
            busy_reg        <= '0;
            user_count_reg  <= '0;
            present_reg     <= 1'b0;
            entry_count_reg <= '0;
        end
        else
        begin
            addr_reg        <= addr_next;
            size_reg        <= size_next;
            owner_reg       <= owner_next;
            busy_reg        <= busy_next;
            user_count_reg  <= user_count_next;
            present_reg     <= present_next;
            entry_count_reg <= entry_count_next;
        end
    end

`ifndef SYNTHESIS
    a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(entry_count_reg) <= MAX_SLOTS)
        else $error("entry count exceeds the pool size");

    a_absent_no_users: assert property (@(posedge clk) disable iff (!rst_n)
        !present_reg |-> user_count_reg == '0)
        else $error("users counted while the pool is absent");

    a_clear_drops_pool: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && rsp.pool_cleared |=> !present_reg && busy_reg == '0)
        else $error("pool not cleared after the last detach");

    a_alloc_marks_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req.req_type == REQ_ALLOC && rsp.status == ST_OK
        |=> busy_reg[$past(alloc_pick)])
        else $error("granted descriptor not marked busy");
`endif

endmodule

[design/buffer_pool_first_fit_allocator.sv]
// Top level of the first-fit buffer pool allocator: input register, pool, response register.
// Depends on bpfa_pkg, bpfa_req_reg and bpfa_pool.
//
//  channel   signals                           direction  content
//  s_*       s_tvalid s_tready s_tuser s_tdata in         one request
//  m_*       m_tvalid m_tready m_tuser m_tdata out        one response per request
//  cfg_*     cfg_valid cfg_ready cfg_data      in         entry count register
//
// A request is held in the input register and decided from there in a single pass over all
// descriptors, and its response is registered; one request per cycle is sustained while the
// response side does not stall.
// Reset clears every descriptor, the user count, the pool mark and the entry count.
// A stalled response holds the response register, and the input register then
// takes at most one more request.
module buffer_pool_first_fit_allocator
    import bpfa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    // req_type [2:0]
    input  logic [TYPE_W-1:0]   s_tuser,
    // user_id [7:0], entry_index [12:8], address_value [44:13], size_value [76:45]
    input  logic [S_DATA_W-1:0] s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    // status [1:0]
    output logic [STATUS_W-1:0] m_tuser,
    // found [0], granted_address [32:1], granted_size [64:33], granted_index [69:65],
    // pool_cleared [70]
    output logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [ENTRY_W-1:0]  cfg_data
);

    logic req_valid;
    req_t req;
    rsp_t rsp;
    logic take;
    logic out_valid_reg;
    logic out_valid_next;
    rsp_t rsp_reg;

    assign take           = req_valid && (!out_valid_reg || m_tready);
    assign out_valid_next = take || (out_valid_reg && !m_tready);
    assign cfg_ready      = 1'b1;

    bpfa_req_reg u_req_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .take      (take),
        .req_valid (req_valid),
        .req       (req)
    );

    bpfa_pool #(
        .MAX_SLOTS (MAX_SLOTS)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .req_valid (take),
        .req       (req),
        .rsp       (rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            rsp_reg <= rsp;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rsp_reg.status;
    assign m_tdata  = {1'b0, rsp_reg.pool_cleared, rsp_reg.granted_index,
                       rsp_reg.granted_size, rsp_reg.granted_address, rsp_reg.found};

`ifndef SYNTHESIS
    a_empty_takes: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg && req_valid |-> take)
        else $error("pending request not taken while the response register is empty");

    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> m_tvalid)
        else $error("taken request produced no response");

    a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled while the output side is free");
`endif

endmodule

[sim/pool_response_checker.sv]
`timescale 1ns / 1ps
// Response checker for the first-fit buffer pool allocator: keeps its own copy of the
// descriptor table, predicts the response to every request and compares it with the output.
// Depends on bpfa_pkg.
module pool_response_checker
    import bpfa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [TYPE_W-1:0]   s_tuser,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [STATUS_W-1:0] m_tuser,
    input  logic [M_DATA_W-1:0] m_tdata,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [ENTRY_W-1:0]  cfg_data,
    output int                  pending,
    output int                  failures
);

    localparam int              SLOTS     = MAX_SLOTS_DEF;
    localparam logic [SIZE_W:0] PAGE_MASK = 33'h0_0000_0FFF;
    localparam logic [SIZE_W-1:0] SIZE_CAP = 32'hFFFF_F000;

    logic [ADDR_W-1:0] pool_addr  [SLOTS];
    logic [SIZE_W-1:0] pool_size  [SLOTS];
    logic              pool_busy  [SLOTS];
    logic [USER_W-1:0] pool_owner [SLOTS];
    logic [7:0]        users;
    logic              present;
    int                active_slots;
    rsp_t              due_responses [$];

    function automatic logic [SIZE_W-1:0] round_to_page(input logic [SIZE_W-1:0] bytes);
        logic [SIZE_W:0] rounded;
        rounded = ({1'b0, bytes} + PAGE_MASK) & ~PAGE_MASK;
        return (rounded > {1'b0, SIZE_CAP}) ? SIZE_CAP : rounded[SIZE_W-1:0];
    endfunction

    function automatic void clear_pool();
        for (int i = 0; i < SLOTS; i++)
        begin
            pool_addr[i]  = '0;
            pool_size[i]  = '0;
            pool_busy[i]  = 1'b0;
            pool_owner[i] = '0;
        end
        users   = '0;
        present = 1'b0;
    endfunction

    function automatic rsp_t serve_request(input logic [TYPE_W-1:0] kind,
                                           input logic [USER_W-1:0] user,
                                           input logic [IDX_W-1:0]  slot,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [SIZE_W-1:0] bytes);
        rsp_t rsp;
        logic hit;
        rsp        = '0;
        rsp.status = ST_REJECT;
        hit        = 1'b0;
        if (kind == REQ_LOAD)
        begin
            if (slot < SLOTS)
            begin
                pool_addr[slot]  = addr;
                pool_size[slot]  = round_to_page(bytes);
                pool_busy[slot]  = 1'b0;
                pool_owner[slot] = '0;
                present          = 1'b1;
                rsp.status       = ST_OK;
            end
        end
        else if (present)
        begin
            case (kind)
                REQ_ATTACH:
                begin
                    if (users != 8'hFF)
                        users++;
                    rsp.status = ST_OK;
                end
                REQ_DETACH:
                begin
                    if (users != 0)
                        users--;
                    if (users != 0)
                    begin
                        for (int i = 0; i < active_slots; i++)
                            if (pool_size[i] != 0 && pool_busy[i] && pool_owner[i] == user)
                                pool_busy[i] = 1'b0;
                    end
                    else
                    begin
                        clear_pool();
                        rsp.pool_cleared = 1'b1;
                    end
                    rsp.status = ST_OK;
                end
                REQ_ALLOC:
                begin
                    for (int i = 0; i < active_slots && !hit; i++)
                        if (!pool_busy[i] && pool_size[i] >= bytes)
                        begin
                            hit                 = 1'b1;
                            pool_busy[i]        = 1'b1;
                            pool_owner[i]       = user;
                            rsp.granted_address = pool_addr[i];
                            rsp.granted_size    = pool_size[i];
                            rsp.granted_index   = IDX_W'(i);
                            rsp.status          = ST_OK;
                        end
                end
                REQ_RELEASE:
                begin
                    rsp.status = ST_NOT_FOUND;
                    for (int i = 0; i < active_slots && !hit; i++)
                        if (pool_addr[i] == addr)
                        begin
                            hit               = 1'b1;
                            pool_busy[i]      = 1'b0;
                            rsp.granted_index = IDX_W'(i);
                            rsp.status        = ST_OK;
                        end
                end
                REQ_QUERY:
                begin
                    rsp.status = ST_OK;
                    for (int i = 0; i < active_slots; i++)
                        if (pool_addr[i] == addr)
                            rsp.found = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        return rsp;
    endfunction

    function automatic int field_mismatch(input string name, input logic [31:0] want,
                                          input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t got;
        int   errs;
        if (!rst_n)
        begin
            clear_pool();
            active_slots = 0;
            due_responses.delete();
            pending  <= 0;
            failures <= 0;
        end
        else
        begin
            errs = 0;
            if (m_tvalid && m_tready)
            begin
                got.status          = m_tuser;
                got.found           = m_tdata[0];
                got.granted_address = m_tdata[32:1];
                got.granted_size    = m_tdata[64:33];
                got.granted_index   = m_tdata[69:65];
                got.pool_cleared    = m_tdata[70];
                if (due_responses.size() == 0)
                begin
                    $display("%0t: response with no request outstanding: expected none, actual %h %h",
                             $time, m_tuser, m_tdata);
                    errs++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    errs += field_mismatch("status", 32'(want.status), 32'(got.status));
                    errs += field_mismatch("found", 32'(want.found), 32'(got.found));
                    errs += field_mismatch("granted_address", want.granted_address,
                                           got.granted_address);
                    errs += field_mismatch("granted_size", want.granted_size, got.granted_size);
                    errs += field_mismatch("granted_index", 32'(want.granted_index),
                                           32'(got.granted_index));
                    errs += field_mismatch("pool_cleared", 32'(want.pool_cleared),
                                           32'(got.pool_cleared));
                end
            end
            if (cfg_valid && cfg_ready)
                active_slots = (cfg_data > SLOTS) ? SLOTS : int'(cfg_data);
            if (s_tvalid && s_tready)
                due_responses.push_back(serve_request(s_tuser, s_tdata[7:0], s_tdata[12:8],
                                                      s_tdata[44:13], s_tdata[76:45]));
            pending  <= due_responses.size();
            failures <= failures + errs;
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// Testbench top for the first-fit buffer pool allocator: clock, reset, request traffic,
// entry count writes, a randomly stalling response side and the final verdict.
// Depends on bpfa_pkg, the allocator RTL and pool_response_checker.
module tb_top;
    import bpfa_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_RSVD_LO = 3'd6;
    localparam logic [TYPE_W-1:0] REQ_RSVD_HI = 3'd7;
    localparam int TOTAL_REQUESTS = 1015;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 8;
    localparam int CYCLE_LIMIT    = 600000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [TYPE_W-1:0]   s_tuser   = '0;
    logic [S_DATA_W-1:0] s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [STATUS_W-1:0] m_tuser;
    logic [M_DATA_W-1:0] m_tdata;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [ENTRY_W-1:0]  cfg_data  = '0;

    int                  pending;
    int                  failures;
    int                  sent_count  = 0;
    int                  cycle_count = 0;
    int                  slot_span   = 0;
    bit                  tx_gaps     = 1'b1;
    bit                  rx_steady   = 1'b0;
    bit                  hold_off_req = 1'b0;
    logic [ADDR_W-1:0]   addr_book [MAX_SLOTS_DEF];
    logic [USER_W-1:0]   crew [4];

    buffer_pool_first_fit_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    pool_response_checker response_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .failures  (failures)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic int gap_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_req(input logic [TYPE_W-1:0] kind, input logic [USER_W-1:0] user,
                            input logic [IDX_W-1:0] slot, input logic [ADDR_W-1:0] addr,
                            input logic [SIZE_W-1:0] bytes);
        int gap;
        gap = tx_gaps ? gap_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, bytes, addr, slot, user};
        do @(posedge clk); while (!s_tready);
        sent_count++;
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_entry_count(input logic [ENTRY_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        slot_span = (value > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF : int'(value);
    endtask

    task automatic load_slot(input logic [IDX_W-1:0] slot);
        int                pick;
        logic [SIZE_W-1:0] bytes;
        pick  = $urandom_range(0, 19);
        bytes = (pick < 2) ? '0 : (pick < 5) ? SIZE_W'($urandom)
                                             : SIZE_W'($urandom_range(1, 32'h4_0000));
        send_req(REQ_LOAD, USER_W'($urandom), slot, addr_book[slot % MAX_SLOTS_DEF], bytes);
    endtask

    // The response side stalls at random, switches between calm and gappy stretches,
    // and honors one long hold-off requested by the stimulus.
    initial
    begin
        int stall_left;
        int open_left;
        stall_left = 0;
        open_left  = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (open_left > 0)
                    open_left--;
                else
                begin
                    open_left = $urandom_range(0, 15);
                    if (!rx_steady)
                        stall_left = gap_len();
                    if ($urandom_range(0, 9) == 0)
                        rx_steady = !rx_steady;
                end
            end
        end
    end

    initial
    begin
        int                seg;
        int                pick;
        int                sel;
        logic [USER_W-1:0] who;
        logic [ADDR_W-1:0] spot;
        logic [SIZE_W-1:0] need;
        logic [IDX_W-1:0]  slot;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Requests while the pool is absent, rejected loads and unknown kinds.
        send_req(REQ_QUERY, 8'h00, 5'd0, 32'h0000_0000, 32'h0);
        send_req(REQ_ATTACH, 8'h01, 5'd0, 32'h0, 32'h0);
        send_req(REQ_DETACH, 8'h01, 5'd0, 32'h0, 32'h0);
        send_req(REQ_ALLOC, 8'h01, 5'd0, 32'h0, 32'h0);
        send_req(REQ_RELEASE, 8'h01, 5'd0, 32'h0, 32'h0);
        send_req(REQ_LOAD, 8'h00, 5'd20, 32'h1000, 32'h1000);
        send_req(REQ_LOAD, 8'hFF, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_RSVD_LO, 8'h00, 5'd0, 32'h0, 32'h0);
        wait_idle();
        write_entry_count(5'd20);

        // Size rounding and saturation, first fit over a zero-sized slot, releases, queries and a clearing detach.
        send_req(REQ_LOAD, 8'h00, 5'd0, 32'h0000_0000, 32'h0);
        send_req(REQ_LOAD, 8'h00, 5'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_LOAD, 8'h00, 5'd19, 32'h1234_5678, 32'h1);
        send_req(REQ_LOAD, 8'h00, 5'd2, 32'h0000_A000, 32'h1000);
        send_req(REQ_RSVD_HI, 8'hFF, 5'd31, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_req(REQ_ATTACH, 8'hFF, 5'd0, 32'h0, 32'h0);
        send_req(REQ_ATTACH, 8'h00, 5'd0, 32'h0, 32'h0);
        send_req(REQ_ALLOC, 8'hAA, 5'd0, 32'h0, 32'h0);
        send_req(REQ_ALLOC, 8'h55, 5'd0, 32'h0, 32'hFFFF_FFFF);
        send_req(REQ_ALLOC, 8'h55, 5'd0, 32'h0, 32'hFFFF_F000);
        send_req(REQ_RELEASE, 8'h00, 5'd0, 32'h0000_0000, 32'h0);
        send_req(REQ_RELEASE, 8'h00, 5'd0, 32'h0000_0000, 32'h0);
        send_req(REQ_RELEASE, 8'h00, 5'd0, 32'hDEAD_0000, 32'h0);
        send_req(REQ_QUERY, 8'h00, 5'd0, 32'h1234_5678, 32'h0);
        send_req(REQ_QUERY, 8'h00, 5'd0, 32'h0000_0005, 32'h0);
        send_req(REQ_DETACH, 8'h55, 5'd0, 32'h0, 32'h0);
        send_req(REQ_DETACH, 8'hAA, 5'd0, 32'h0, 32'h0);
        send_req(REQ_QUERY, 8'h00, 5'd0, 32'h1234_5678, 32'h0);

        seg = 0;
        while (sent_count < TOTAL_REQUESTS)
        begin
            wait_idle();
            pick = $urandom_range(0, 99);
            if (seg == 0)
                write_entry_count(5'd20);
            else if (seg == 1)
                write_entry_count(5'd0);
            else if (seg == 3)
                write_entry_count(5'd31);
            else if (pick < 10)
                write_entry_count(5'd0);
            else if (pick < 25)
                write_entry_count(5'd20);
            else
                write_entry_count(ENTRY_W'($urandom_range(1, 20)));

            for (int i = 0; i < MAX_SLOTS_DEF; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    addr_book[i] = '0;
                else if (pick == 1)
                    addr_book[i] = '1;
                else if (pick == 2 && i > 0)
                    addr_book[i] = addr_book[i-1];
                else
                    addr_book[i] = ADDR_W'($urandom);
            end
            for (int k = 0; k < 4; k++)
                crew[k] = USER_W'($urandom);
            tx_gaps = ($urandom_range(0, 3) != 0);
            if (seg == 2)
            begin
                tx_gaps      = 1'b0;
                hold_off_req = 1'b1;
            end

            for (int i = 0; i < slot_span; i++)
                load_slot(IDX_W'(i));
            repeat ($urandom_range(1, 3))
                send_req(REQ_ATTACH, crew[$urandom_range(0, 3)], IDX_W'($urandom),
                         ADDR_W'($urandom), SIZE_W'($urandom));
            if (seg == 0)
            begin
                // Drive the user count into saturation, then step it back down once.
                repeat (258)
                    send_req(REQ_ATTACH, USER_W'($urandom), IDX_W'($urandom), 32'h0, 32'h0);
                send_req(REQ_DETACH, crew[0], 5'd0, 32'h0, 32'h0);
            end

            repeat ($urandom_range(40, 80))
            begin
                pick = $urandom_range(0, 99);
                who  = ($urandom_range(0, 7) == 0) ? USER_W'($urandom)
                                                   : crew[$urandom_range(0, 3)];
                spot = ($urandom_range(0, 3) == 0) ? ADDR_W'($urandom)
                                                   : addr_book[$urandom_range(0, 19)];
                sel  = $urandom_range(0, 9);
                need = (sel < 2) ? '0 : (sel < 8) ? SIZE_W'($urandom_range(0, 32'h4_0000))
                                                  : SIZE_W'($urandom);
                slot = (slot_span == 0 || $urandom_range(0, 6) == 0)
                       ? IDX_W'($urandom_range(0, 31))
                       : IDX_W'($urandom_range(0, slot_span - 1));
                if (pick < 30)
                    send_req(REQ_ALLOC, who, IDX_W'($urandom), ADDR_W'($urandom), need);
                else if (pick < 48)
                    send_req(REQ_RELEASE, who, IDX_W'($urandom), spot, SIZE_W'($urandom));
                else if (pick < 62)
                    send_req(REQ_QUERY, who, IDX_W'($urandom), spot, SIZE_W'($urandom));
                else if (pick < 70)
                    send_req(REQ_ATTACH, who, IDX_W'($urandom), spot, need);
                else if (pick < 76)
                    send_req(REQ_DETACH, who, IDX_W'($urandom), spot, need);
                else if (pick < 88)
                    load_slot(slot);
                else if (pick < 94)
                    send_req(pick[0] ? REQ_RSVD_LO : REQ_RSVD_HI, who, slot, spot, need);
                else
                    send_req(TYPE_W'($urandom_range(REQ_LOAD, REQ_QUERY)), USER_W'($urandom),
                             IDX_W'($urandom), ADDR_W'($urandom), SIZE_W'($urandom));
            end
            seg++;
        end

        wait_idle();
        if (failures == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[buffer_pool_first_fit_allocator.f]
design/bpfa_pkg.sv
design/bpfa_req_reg.sv
design/bpfa_pool.sv
design/buffer_pool_first_fit_allocator.sv
sim/pool_response_checker.sv
sim/tb_top.sv
